[rtl/irw_pkg.sv]
// Shared types, constants and calibration tables for the IR wall distance block.
package irw_pkg;

    // Fixed field widths
    localparam int CH_W        = 2;
    localparam int SAMPLE_BITS = 12;
    localparam int MM_W        = 8;
    localparam int DIST_W      = 16;
    localparam int FRAC_W      = 8;
    localparam int SHIFT_W     = 4;
    localparam int LIM_W       = MM_W + 2;

    // Default channel count
    localparam int CHANNELS_DEF = 4;

    // Calibration table
    localparam int ROM_ROWS   = 4;
    localparam int ROM_COLS   = 6;
    localparam int CAL_POINTS = 6;
    localparam int CAL_N      = (CAL_POINTS < ROM_COLS) ? CAL_POINTS : ROM_COLS;

    localparam logic [SAMPLE_BITS-1:0] ROM_ADC [ROM_ROWS][ROM_COLS] = '{
        '{12'd2383, 12'd1433, 12'd962,  12'd592,  12'd424,  12'd310},
        '{12'd3286, 12'd2117, 12'd1366, 12'd1039, 12'd753,  12'd568},
        '{12'd3344, 12'd3125, 12'd2019, 12'd1514, 12'd1030, 12'd721},
        '{12'd3287, 12'd2387, 12'd1502, 12'd1080, 12'd659,  12'd442}
    };
    localparam logic [MM_W-1:0] ROM_MM [ROM_COLS] = '{
        8'd30, 8'd50, 8'd70, 8'd90, 8'd120, 8'd160
    };

    // Divider operand widths: (a0 - f) * dm * 256 over the segment span
    localparam int NUM_W = SAMPLE_BITS + MM_W + FRAC_W;
    localparam int DEN_W = SAMPLE_BITS;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_BAND    = 2'd2;
    localparam logic [SHIFT_W-1:0]   SHIFT_RESET      = 4'd3;
    localparam logic [MM_W-1:0]      LIMIT_RESET      = 8'd90;
    localparam logic [MM_W-1:0]      BAND_RESET       = 8'd10;

    // Stream payload widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int TUSER_W     = CH_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_SEG,
        S_MUL,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[rtl/ir_reflect_filter_distance_wall.sv]
// Top level: ambient-cancelled IR reflectance to filtered wall distance and wall flag.
//
// Each input word carries one channel's ambient and lit 12-bit samples; the block
// returns one result word per input word with the reflected level (ambient minus lit,
// floored at zero), the updated per-channel exponential average, the distance in
// unsigned Q8.8 millimetres from the channel's six-point calibration table, and the
// per-channel wall flag with hysteresis. Items are processed one at a time: acceptance
// is followed by four set-up steps, the 28-step bit-serial divider that forms the
// interpolation term, a step to see the division finish and a step to load the result;
// the next word is accepted the cycle after the result is loaded into the output
// register. A result still waiting on the master side holds the item in its load
// step, so the next item cannot start until it is taken. All per-channel state
// clears at reset; configuration writes are taken at any time and are expected only
// while the block is idle. Channel numbers at or above CHANNELS wrap onto the state;
// the calibration row is always the channel number itself.
module ir_reflect_filter_distance_wall #(
    parameter int CHANNELS = irw_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [11:0] ambient_sample, [23:12] lit_sample
    input  logic [irw_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [1:0] channel
    input  logic [irw_pkg::TUSER_W-1:0]         i_s_tuser,
    // Result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [11:0] reflected, [23:12] filtered, [39:24] distance_q8, [40] wall_present,
    // [47:41] zero
    output logic [irw_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [1:0] channel_out
    output logic [irw_pkg::TUSER_W-1:0]         o_m_tuser,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [irw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [irw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB    = irw_pkg::SAMPLE_BITS;
    localparam int MW    = irw_pkg::MM_W;

    // Sequencer
    irw_pkg::t_state r_state;
    irw_pkg::t_state n_state;

    // Configuration
    logic [irw_pkg::SHIFT_W-1:0] r_shift;
    logic [MW-1:0]               r_limit;
    logic [MW-1:0]               r_band;

    // Per-channel state
    logic [SB-1:0] r_level [CHANNELS];
    logic          r_wall  [CHANNELS];

    // Item working registers
    logic [irw_pkg::CH_W-1:0] r_ch;
    logic [IDX_W-1:0]         r_idx;
    logic [SB-1:0]            r_refl;
    logic [SB-1:0]            r_filt;
    logic [SB-1:0]            r_diff;
    logic [MW-1:0]            r_dm;
    logic [SB-1:0]            r_den;
    logic [MW-1:0]            r_mm0;
    logic [irw_pkg::NUM_W-1:0] r_num;

    // Output register
    logic                           r_m_valid;
    logic [irw_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic [irw_pkg::TUSER_W-1:0]    r_m_user;

    // Control
    logic              w_accept;
    logic              w_load;
    irw_pkg::t_div_ctl w_div_ctl;
    irw_pkg::t_div_sts w_div_sts;
    logic [irw_pkg::NUM_W-1:0] w_quot;

    // Datapath
    logic [SB-1:0]             w_amb;
    logic [SB-1:0]             w_lit;
    logic [SB-1:0]             w_refl;
    logic [irw_pkg::CH_W-1:0]  w_mod;
    logic [SB-1:0]             w_prev;
    logic [SB-1:0]             w_filt;
    logic [irw_pkg::CAL_N-1:0] w_ge;
    logic [MW-1:0]             w_mm0;
    logic [SB-1:0]             w_diff;
    logic [MW-1:0]             w_dm;
    logic [SB-1:0]             w_span;
    logic [SB+MW-1:0]          w_mul;
    logic signed [irw_pkg::LIM_W-1:0] w_lim;
    logic [irw_pkg::DIST_W-1:0] w_dist;
    logic                      w_wall;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            irw_pkg::S_IDLE:  if (i_s_tvalid) n_state = irw_pkg::S_FILT;
            irw_pkg::S_FILT:  n_state = irw_pkg::S_SEG;
            irw_pkg::S_SEG:   n_state = irw_pkg::S_MUL;
            irw_pkg::S_MUL:   n_state = irw_pkg::S_START;
            irw_pkg::S_START: n_state = irw_pkg::S_DIV;
            irw_pkg::S_DIV:   if (w_div_sts.done) n_state = irw_pkg::S_OUT;
            irw_pkg::S_OUT:   if (!r_m_valid || i_m_tready) n_state = irw_pkg::S_IDLE;
            default:          n_state = irw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_load          = 1'b0;
        case (r_state)
            irw_pkg::S_IDLE:  o_s_tready = 1'b1;
            irw_pkg::S_START: w_div_ctl.start = 1'b1;
            irw_pkg::S_OUT:   w_load = !r_m_valid || i_m_tready;
            default: begin
                o_s_tready      = 1'b0;
                w_div_ctl.start = 1'b0;
                w_load          = 1'b0;
            end
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    // ---------------------------------------------------------------- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= irw_pkg::SHIFT_RESET;
            r_limit <= irw_pkg::LIMIT_RESET;
            r_band  <= irw_pkg::BAND_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                irw_pkg::CFG_FILTER_SHIFT: r_shift <= i_cfg_data[irw_pkg::SHIFT_W-1:0];
                irw_pkg::CFG_WALL_LIMIT:   r_limit <= i_cfg_data;
                irw_pkg::CFG_WALL_BAND:    r_band  <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------- acceptance
    assign w_amb  = i_s_tdata[SB-1:0];
    assign w_lit  = i_s_tdata[2*SB-1:SB];
    assign w_refl = (w_amb > w_lit) ? (w_amb - w_lit) : '0;

    // Wrap the channel number onto the state depth; at most four subtractions
    always_comb begin
        w_mod = i_s_tuser;
        for (int k = 0; k < 4; k++) begin
            if (32'(w_mod) >= CHANNELS) begin
                w_mod = w_mod - irw_pkg::CH_W'(CHANNELS);
            end
        end
    end

    // ---------------------------------------------------------------- smoothing
    assign w_prev = r_level[r_idx];

    // Move the average by the shifted gap toward the new level
    always_comb begin
        if (r_refl > w_prev) begin
            w_filt = w_prev + ((r_refl - w_prev) >> r_shift);
        end else begin
            w_filt = w_prev - ((w_prev - r_refl) >> r_shift);
        end
    end

    // ---------------------------------------------------------------- segment search
    always_comb begin
        for (int k = 0; k < irw_pkg::CAL_N; k++) begin
            w_ge[k] = (r_filt >= irw_pkg::ROM_ADC[r_ch][k]);
        end
    end

    // Below the last point: clamp to the far end; the lowest matching segment wins
    always_comb begin
        w_mm0  = irw_pkg::ROM_MM[irw_pkg::CAL_N-1];
        w_diff = '0;
        w_dm   = '0;
        w_span = SB'(1);
        for (int i = irw_pkg::CAL_N - 2; i >= 0; i--) begin
            if (w_ge[i+1]) begin
                w_mm0  = irw_pkg::ROM_MM[i];
                w_diff = irw_pkg::ROM_ADC[r_ch][i] - r_filt;
                w_dm   = irw_pkg::ROM_MM[i+1] - irw_pkg::ROM_MM[i];
                w_span = irw_pkg::ROM_ADC[r_ch][i] - irw_pkg::ROM_ADC[r_ch][i+1];
            end
        end
        // At or above the first point: clamp to the near end
        if (w_ge[0]) begin
            w_mm0  = irw_pkg::ROM_MM[0];
            w_diff = '0;
            w_dm   = '0;
            w_span = SB'(1);
        end
        // Flat segment: divide by one
        if (w_span == '0) begin
            w_span = SB'(1);
        end
    end

    assign w_mul = r_diff * r_dm;

    // ---------------------------------------------------------------- shared divider
    irw_div #(
        .N_W (irw_pkg::NUM_W),
        .D_W (irw_pkg::DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    // ---------------------------------------------------------------- distance and wall
    assign w_dist = irw_pkg::DIST_W'({r_mm0, {irw_pkg::FRAC_W{1'b0}}})
                  + w_quot[irw_pkg::DIST_W-1:0];

    // Widen the threshold when the wall is already seen, narrow it otherwise
    always_comb begin
        if (r_wall[r_idx]) begin
            w_lim = $signed({2'b00, r_limit}) + $signed({2'b00, r_band});
        end else begin
            w_lim = $signed({2'b00, r_limit}) - $signed({2'b00, r_band});
        end
    end

    assign w_wall = $signed({2'b00, w_dist}) < $signed({w_lim, {irw_pkg::FRAC_W{1'b0}}});

    // ---------------------------------------------------------------- state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_level[k] <= '0;
                r_wall[k]  <= 1'b0;
            end
        end else begin
            if (r_state == irw_pkg::S_FILT) begin
                r_level[r_idx] <= w_filt;
            end
            if (w_load) begin
                r_wall[r_idx] <= w_wall;
            end
        end
    end

    // Working registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_s_tuser;
            r_idx  <= IDX_W'(w_mod);
            r_refl <= w_refl;
        end
        if (r_state == irw_pkg::S_FILT) begin
            r_filt <= w_filt;
        end
        if (r_state == irw_pkg::S_SEG) begin
            r_mm0  <= w_mm0;
            r_diff <= w_diff;
            r_dm   <= w_dm;
            r_den  <= w_span;
        end
        if (r_state == irw_pkg::S_MUL) begin
            r_num <= {w_mul, {irw_pkg::FRAC_W{1'b0}}};
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_user <= r_ch;
            r_m_data <= {7'b0, w_wall, w_dist, r_filt, r_refl};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // ---------------------------------------------------------------- assertions
    // The divider is only started once the previous division has finished
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |-> !w_div_sts.busy)
        else $error("divider started while busy");

    // A division completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == irw_pkg::S_DIV))
        else $error("divider finished outside the wait state");

    // Taking a word closes the input until the item is finished
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input accepted during an item");

    // The reported average is the one stored for the channel
    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_level[r_idx] == r_filt))
        else $error("stored average differs from the reported one");

endmodule

[rtl/irw_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module irw_div #(
    parameter int N_W = irw_pkg::NUM_W,
    parameter int D_W = irw_pkg::DEN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irw_pkg::t_div_ctl i_ctl,
    input  logic [N_W-1:0]    i_num,
    input  logic [D_W-1:0]    i_den,
    output irw_pkg::t_div_sts o_sts,
    output logic [N_W-1:0]    o_quot
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_den;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_qbit;

    assign w_trial = {r_rem, r_num[N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = ~w_diff[D_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift the quotient in from the bottom as the dividend leaves the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_num <= {r_num[N_W-2:0], w_qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_num;

endmodule
